[sv/roc_pkg.sv]
// Shared types and constants for the refcounted object cache.
// No dependencies; every other file of the block imports this package.
package roc_pkg;

   localparam int ENTRIES_DEF  = 32;
   localparam int REF_BITS_DEF = 16;
   localparam int MAX_RESULTS  = 32;

   localparam int CMD_W    = 3;
   localparam int DEV_W    = 16;
   localparam int OBJ_W    = 32;
   localparam int SLOT_W   = 5;
   localparam int DROP_W   = 16;
   localparam int STATUS_W = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_GET        = 3'd0,
      CMD_FIND       = 3'd1,
      CMD_PUT        = 3'd2,
      CMD_PUT_COUNT  = 3'd3,
      CMD_MARK_DIRTY = 3'd4,
      CMD_SYNC       = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_MISS_FILL   = 3'd1,
      ST_NOT_FOUND   = 3'd2,
      ST_FULL        = 3'd3,
      ST_BAD_RELEASE = 3'd4,
      ST_OVERFLOW    = 3'd5
   } status_type;

   // shared unit operation
   typedef enum logic {
      UOP_INC = 1'b0,
      UOP_SUB = 1'b1
   } uop_type;

   typedef struct packed {
      logic tag_eq;  // stored tag equals item tag
      logic carry;   // INC: count at max; SUB: borrow
      logic zero;    // low REF_BITS of result are zero
   } unit_flags_type;

endpackage

[sv/roc_req_if.sv]
// Request channel of the object cache: valid/ready plus one command word.
// Depends on roc_pkg.
interface roc_req_if;
   import roc_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DEV_W-1:0]  device;
   logic [OBJ_W-1:0]  object_number;
   logic [SLOT_W-1:0] slot;
   logic [DROP_W-1:0] drop_count;

   modport source (output valid, command, device, object_number, slot, drop_count,
                   input ready);
   modport sink   (input valid, command, device, object_number, slot, drop_count,
                   output ready);
endinterface

[sv/roc_rsp_if.sv]
// Response channel of the object cache: valid/ready plus one result word.
// Depends on roc_pkg.
interface roc_rsp_if;
   import roc_pkg::*;

   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   result_slot;
   logic [STATUS_W-1:0] status;
   logic                writeback;
   logic [DEV_W-1:0]    wb_device;
   logic [OBJ_W-1:0]    wb_object_number;
   logic                last;

   modport source (output valid, result_slot, status, writeback, wb_device,
                   wb_object_number, last, input ready);
   modport sink   (input valid, result_slot, status, writeback, wb_device,
                   wb_object_number, last, output ready);
endinterface

[sv/roc_unit.sv]
// Shared compare/arithmetic unit: tag match and reference count add/subtract.
// Depends on roc_pkg; used by the cache sequencer.
module roc_unit #(
   parameter int REF_BITS = roc_pkg::REF_BITS_DEF
) (
   input  roc_pkg::uop_type          op,
   input  logic [REF_BITS-1:0]       refs,
   input  logic [roc_pkg::DROP_W-1:0] operand,
   input  logic [roc_pkg::DEV_W-1:0] dev_a,
   input  logic [roc_pkg::OBJ_W-1:0] obj_a,
   input  logic [roc_pkg::DEV_W-1:0] dev_b,
   input  logic [roc_pkg::OBJ_W-1:0] obj_b,
   output logic [REF_BITS-1:0]       result,
   output roc_pkg::unit_flags_type   flags
);
   import roc_pkg::*;

   localparam int OPW = (REF_BITS > DROP_W) ? REF_BITS : DROP_W;

   logic [OPW-1:0] a_ext;
   logic [OPW-1:0] b_ext;
   logic [OPW:0]   sum;

   always_comb begin
      a_ext = OPW'(refs);
      b_ext = OPW'(operand);
      if (op == UOP_INC) begin
         sum = {1'b0, a_ext} + {1'b0, b_ext};
      end else begin
         sum = {1'b0, a_ext} - {1'b0, b_ext};
      end
      result = sum[REF_BITS-1:0];
      flags.tag_eq = (dev_a == dev_b) && (obj_a == obj_b);
      // the count is REF_BITS bits wide, so a carry into bit REF_BITS means it was at max
      flags.carry  = (op == UOP_INC) ? sum[REF_BITS] : sum[OPW];
      flags.zero   = (sum[REF_BITS-1:0] == '0);
   end

endmodule

[sv/refcounted_object_cache_core.sv]
// Refcounted object cache: tag table, free-slot stack and command sequencer.
// Depends on roc_pkg, roc_req_if, roc_rsp_if and roc_unit.
//
//   channel  dir  handshake      word
//   req_ch   in   valid/ready    command, device, object_number, slot, drop_count
//   rsp_ch   out  valid/ready    result_slot, status, writeback, wb tag, last
//
// One command at a time. Get/find/put by count scan the tag memory one entry
// per cycle through its single read port; a get that misses then pops the
// free-slot stack. Put slot reads its entry once; mark dirty needs no read. Sync
// walks the entries and reads each dirty one, up to MAX_RESULTS of them.
// Reset clears valid/dirty bits and sets the stack pointer to ENTRIES at once; no clearing pass.
// A full response register that is not taken holds the sequencer at any step that must emit.
module refcounted_object_cache_core #(
   parameter int ENTRIES  = roc_pkg::ENTRIES_DEF,
   parameter int REF_BITS = roc_pkg::REF_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   roc_req_if.sink  req_ch,
   roc_rsp_if.source rsp_ch
);
   import roc_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int PW    = IDX_W + 1;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_DISP    = 7'b0000010,
      S_SCAN    = 7'b0000100,
      S_READ    = 7'b0001000,
      S_ALLOC   = 7'b0010000,
      S_SYNC    = 7'b0100000,
      S_SYNC_RD = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // latched request word
   logic [CMD_W-1:0]  cmd_ff;
   logic [DEV_W-1:0]  dev_ff;
   logic [OBJ_W-1:0]  obj_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [DROP_W-1:0] drop_ff;

   logic [PW-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] dirty_ff, dirty_in;

   // sync holds one found entry back until it knows whether it is the last
   logic              pend_ff, pend_in;
   logic [SLOT_W-1:0] pend_slot_ff;
   logic [DEV_W-1:0]  pend_dev_ff;
   logic [OBJ_W-1:0]  pend_obj_ff;
   logic              pend_load;

   // tag/count memory
   logic [DEV_W-1:0]    dev_mem  [ENTRIES];
   logic [OBJ_W-1:0]    obj_mem  [ENTRIES];
   logic [REF_BITS-1:0] refs_mem [ENTRIES];
   logic                rd_en, wr_en;
   logic [IDX_W-1:0]    rd_addr, wr_addr;
   logic [DEV_W-1:0]    rd_dev_ff, wr_dev;
   logic [OBJ_W-1:0]    rd_obj_ff, wr_obj;
   logic [REF_BITS-1:0] rd_refs_ff, wr_refs;

   // free-slot stack; positions below low_ff were never pushed and hold
   // their own index
   logic [IDX_W-1:0] stk_mem [ENTRIES];
   logic [PW-1:0]    top_ff, top_in;
   logic [PW-1:0]    low_ff, low_in;
   logic [PW-1:0]    top_dec;
   logic             pop_init_ff, pop_init_in;
   logic             push_en, stk_rd_en;
   logic [IDX_W-1:0] push_val, stk_rd_addr, stk_rd_ff;
   logic [IDX_W-1:0] alloc_idx;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic                rsp_wb_ff;
   logic [DEV_W-1:0]    rsp_dev_ff;
   logic [OBJ_W-1:0]    rsp_obj_ff;
   logic                rsp_last_ff;
   logic                out_free;

   logic              emit;
   logic [SLOT_W-1:0] e_slot;
   status_type        e_status;
   logic              e_wb;
   logic [DEV_W-1:0]  e_dev;
   logic [OBJ_W-1:0]  e_obj;
   logic              e_last;

   // shared unit
   uop_type             u_op;
   logic [DROP_W-1:0]   u_operand;
   logic [REF_BITS-1:0] u_result;
   unit_flags_type      u_flags;

   logic             accept;
   logic             slot_oob;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W-1:0] act_idx;
   logic             rel_req;

   roc_unit #(
      .REF_BITS(REF_BITS)
   ) u_unit (
      .op      (u_op),
      .refs    (rd_refs_ff),
      .operand (u_operand),
      .dev_a   (rd_dev_ff),
      .obj_a   (rd_obj_ff),
      .dev_b   (dev_ff),
      .obj_b   (obj_ff),
      .result  (u_result),
      .flags   (u_flags)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign slot_oob  = (int'(slot_ff) >= ENTRIES);
   assign slot_idx  = IDX_W'(slot_ff);
   assign top_dec   = top_ff - PW'(1);
   assign alloc_idx = pop_init_ff ? top_ff[IDX_W-1:0] : stk_rd_ff;

   always_comb begin
      act_idx = (state_ff == S_READ) ? slot_idx : idx_ff[IDX_W-1:0];
      if ((state_ff == S_SCAN) && (cmd_ff == CMD_GET)) begin
         u_op = UOP_INC;
      end else begin
         u_op = UOP_SUB;
      end
      if ((state_ff == S_READ) || (cmd_ff == CMD_GET)) begin
         u_operand = DROP_W'(1);
      end else begin
         u_operand = drop_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      valid_in    = valid_ff;
      dirty_in    = dirty_ff;
      pend_in     = pend_ff;
      pend_load   = 1'b0;
      top_in      = top_ff;
      low_in      = low_ff;
      pop_init_in = pop_init_ff;
      rd_en       = 1'b0;
      rd_addr     = act_idx;
      wr_en       = 1'b0;
      wr_addr     = act_idx;
      wr_dev      = rd_dev_ff;
      wr_obj      = rd_obj_ff;
      wr_refs     = u_result;
      push_en     = 1'b0;
      push_val    = act_idx;
      stk_rd_en   = 1'b0;
      stk_rd_addr = top_dec[IDX_W-1:0];
      rel_req     = 1'b0;
      emit        = 1'b0;
      e_slot      = SLOT_W'(act_idx);
      e_status    = ST_OK;
      e_wb        = 1'b0;
      e_dev       = '0;
      e_obj       = '0;
      e_last      = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_DISP;
            end
         end

         S_DISP: begin
            case (cmd_ff)
               CMD_GET, CMD_FIND, CMD_PUT_COUNT: begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = '0;
                  state_in = S_SCAN;
               end
               CMD_PUT: begin
                  if (slot_oob || !valid_ff[slot_idx]) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        e_slot   = slot_ff;
                        e_status = ST_BAD_RELEASE;
                        state_in = S_IDLE;
                     end
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_idx;
                     state_in = S_READ;
                  end
               end
               CMD_MARK_DIRTY: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_slot   = slot_ff;
                     state_in = S_IDLE;
                     if (slot_oob || !valid_ff[slot_idx]) begin
                        e_status = ST_NOT_FOUND;
                     end else begin
                        dirty_in[slot_idx] = 1'b1;
                     end
                  end
               end
               CMD_SYNC: begin
                  idx_in   = '0;
                  count_in = '0;
                  pend_in  = 1'b0;
                  state_in = S_SYNC;
               end
               default: begin
                  if (out_free) begin
                     emit     = 1'b1;
                     e_slot   = '0;
                     e_status = ST_BAD_RELEASE;
                     state_in = S_IDLE;
                  end
               end
            endcase
         end

         S_SCAN: begin
            if (valid_ff[act_idx] && u_flags.tag_eq) begin
               if (cmd_ff == CMD_PUT_COUNT) begin
                  rel_req = 1'b1;
               end else if (out_free) begin
                  emit     = 1'b1;
                  state_in = S_IDLE;
                  if (cmd_ff == CMD_GET) begin
                     if (u_flags.carry) begin
                        e_status = ST_OVERFLOW;
                     end else begin
                        wr_en = 1'b1;
                     end
                  end
               end
            end else if (idx_ff == PW'(ENTRIES - 1)) begin
               if ((cmd_ff == CMD_GET) && (top_ff != '0)) begin
                  top_in    = top_dec;
                  stk_rd_en = 1'b1;
                  if (top_dec < low_ff) begin
                     pop_init_in = 1'b1;
                     low_in      = top_dec;
                  end else begin
                     pop_init_in = 1'b0;
                  end
                  state_in = S_ALLOC;
               end else if (out_free) begin
                  emit     = 1'b1;
                  e_slot   = '0;
                  e_status = (cmd_ff == CMD_GET) ? ST_FULL : ST_NOT_FOUND;
                  state_in = S_IDLE;
               end
            end else begin
               idx_in  = idx_ff + PW'(1);
               rd_en   = 1'b1;
               rd_addr = idx_in[IDX_W-1:0];
            end
         end

         S_READ: begin
            rel_req = 1'b1;
         end

         S_ALLOC: begin
            if (out_free) begin
               wr_en               = 1'b1;
               wr_addr             = alloc_idx;
               wr_dev              = dev_ff;
               wr_obj              = obj_ff;
               wr_refs             = REF_BITS'(1);
               valid_in[alloc_idx] = 1'b1;
               dirty_in[alloc_idx] = 1'b0;
               emit                = 1'b1;
               e_slot              = SLOT_W'(alloc_idx);
               e_status            = ST_MISS_FILL;
               state_in            = S_IDLE;
            end
         end

         S_SYNC: begin
            if ((count_ff == CNT_W'(MAX_RESULTS)) || (idx_ff == PW'(ENTRIES))) begin
               if (out_free) begin
                  emit     = 1'b1;
                  pend_in  = 1'b0;
                  state_in = S_IDLE;
                  if (pend_ff) begin
                     e_slot = pend_slot_ff;
                     e_wb   = 1'b1;
                     e_dev  = pend_dev_ff;
                     e_obj  = pend_obj_ff;
                  end else begin
                     e_slot = '0;
                  end
               end
            end else if (valid_ff[act_idx] && dirty_ff[act_idx]) begin
               dirty_in[act_idx] = 1'b0;
               rd_en             = 1'b1;
               count_in          = count_ff + CNT_W'(1);
               state_in          = S_SYNC_RD;
            end else begin
               idx_in = idx_ff + PW'(1);
            end
         end

         S_SYNC_RD: begin
            if (!pend_ff || out_free) begin
               if (pend_ff) begin
                  emit   = 1'b1;
                  e_slot = pend_slot_ff;
                  e_wb   = 1'b1;
                  e_dev  = pend_dev_ff;
                  e_obj  = pend_obj_ff;
                  e_last = 1'b0;
               end
               pend_in   = 1'b1;
               pend_load = 1'b1;
               idx_in    = idx_ff + PW'(1);
               state_in  = S_SYNC;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // release of act_idx, shared by put slot and put by count
      if (rel_req && out_free) begin
         emit     = 1'b1;
         state_in = S_IDLE;
         if (u_flags.carry) begin
            e_status = ST_BAD_RELEASE;
         end else begin
            wr_en = 1'b1;
            if (u_flags.zero) begin
               valid_in[act_idx] = 1'b0;
               dirty_in[act_idx] = 1'b0;
               if (dirty_ff[act_idx]) begin
                  e_wb  = 1'b1;
                  e_dev = rd_dev_ff;
                  e_obj = rd_obj_ff;
               end
               if (top_ff < PW'(ENTRIES)) begin
                  push_en = 1'b1;
                  top_in  = top_ff + PW'(1);
               end
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
         pend_ff      <= 1'b0;
         top_ff       <= PW'(ENTRIES);
         low_ff       <= PW'(ENTRIES);
         pop_init_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
         pend_ff      <= pend_in;
         top_ff       <= top_in;
         low_ff       <= low_in;
         pop_init_ff  <= pop_init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_ch.command;
         dev_ff  <= req_ch.device;
         obj_ff  <= req_ch.object_number;
         slot_ff <= req_ch.slot;
         drop_ff <= req_ch.drop_count;
      end
      if (pend_load) begin
         pend_slot_ff <= SLOT_W'(act_idx);
         pend_dev_ff  <= rd_dev_ff;
         pend_obj_ff  <= rd_obj_ff;
      end
      if (emit) begin
         rsp_slot_ff   <= e_slot;
         rsp_status_ff <= e_status;
         rsp_wb_ff     <= e_wb;
         rsp_dev_ff    <= e_dev;
         rsp_obj_ff    <= e_obj;
         rsp_last_ff   <= e_last;
      end
   end

   // tag/count memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dev_mem[wr_addr]  <= wr_dev;
         obj_mem[wr_addr]  <= wr_obj;
         refs_mem[wr_addr] <= wr_refs;
      end
      if (rd_en) begin
         rd_dev_ff  <= dev_mem[rd_addr];
         rd_obj_ff  <= obj_mem[rd_addr];
         rd_refs_ff <= refs_mem[rd_addr];
      end
   end

   // free-slot stack memory
   always_ff @(posedge clock) begin
      if (push_en) begin
         stk_mem[top_ff[IDX_W-1:0]] <= push_val;
      end
      if (stk_rd_en) begin
         stk_rd_ff <= stk_mem[stk_rd_addr];
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.result_slot      = rsp_slot_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.writeback        = rsp_wb_ff;
   assign rsp_ch.wb_device        = rsp_dev_ff;
   assign rsp_ch.wb_object_number = rsp_obj_ff;
   assign rsp_ch.last             = rsp_last_ff;

endmodule

[sv/roc_checker.sv]
// Port-level checks for the object cache core, attached by bind.
// Depends on roc_pkg and refcounted_object_cache_core.
module roc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [roc_pkg::SLOT_W-1:0]    rsp_slot,
   input logic [roc_pkg::STATUS_W-1:0]  rsp_status,
   input logic                          rsp_wb,
   input logic [roc_pkg::DEV_W-1:0]     rsp_dev,
   input logic [roc_pkg::OBJ_W-1:0]     rsp_obj,
   input logic                          rsp_last
);
   import roc_pkg::*;

   // a word not taken stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_status)
         && $stable(rsp_wb) && $stable(rsp_last))
      else $error("response word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // one command at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in flight");

   a_wb_tag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_wb |-> (rsp_dev == '0) && (rsp_obj == '0))
      else $error("writeback tag set without writeback");

   a_error_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |-> rsp_last && !rsp_wb)
      else $error("error status on a non-final or writeback word");

endmodule

bind refcounted_object_cache_core roc_checker u_roc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_slot   (rsp_ch.result_slot),
   .rsp_status (rsp_ch.status),
   .rsp_wb     (rsp_ch.writeback),
   .rsp_dev    (rsp_ch.wb_device),
   .rsp_obj    (rsp_ch.wb_object_number),
   .rsp_last   (rsp_ch.last)
);
